>>> src/triangle_unit_normal_assert.svh
// Assertion macros for the triangle unit normal checks.
// Used by the bound port checker; depends on a clk and rst in scope.
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// check outside reset
`define TUN_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("triangle_unit_normal check failed");

// check on every edge, reset included
`define TUN_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("triangle_unit_normal check failed");

`endif

>>> src/tun_pkg.sv
// Shared widths, types and helpers of the triangle unit normal pipeline.
// No dependencies; every module file imports it.
package tun_pkg;

  localparam int COORD_BITS       = 24;
  localparam int COORD_FRAC_BITS  = 12;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int MINL_BITS        = 25;
  localparam logic [MINL_BITS-1:0] MINL_RESET = MINL_BITS'(1678);

  localparam int EDGE_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int MAG_W    = PROD_W;
  localparam int THR_W    = 2 * MINL_BITS;
  localparam int SQS_W    = THR_W + 2;
  localparam int OUT_W    = NORMAL_FRAC_BITS + 2;
  localparam int Q_W      = NORMAL_FRAC_BITS + 1;
  localparam int NORM_TOP = 30;
  localparam int NSQ_W    = 2 * NORM_TOP;
  localparam int ROOT_W   = NORM_TOP + 1;
  localparam int S2_W     = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int NUM_W    = NORM_TOP + NORMAL_FRAC_BITS + 1;
  localparam int BL_W     = $clog2(MAG_W + 1);
  localparam int SH_W     = $clog2(MAG_W + NORM_TOP + 1);
  localparam int IN_W     = 9 * COORD_BITS;
  localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam int ROUND_D = 2 * COORD_FRAC_BITS - NORMAL_FRAC_BITS;
  localparam int RD      = (ROUND_D > 0) ? ROUND_D : 0;
  localparam int RD1     = (ROUND_D > 0) ? ROUND_D - 1 : 0;
  localparam int LD      = (ROUND_D < 0) ? -ROUND_D : 0;

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << NORMAL_FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [NORM_TOP-1:0]          nmag_t;
  typedef logic [OUT_W-1:0]             comp_t;
  typedef logic [Q_W-1:0]               quo_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic        degen;
    comp_t [2:0] raw;
  } side_t;

  function automatic comp_t pack_comp(logic neg, quo_t q);
    comp_t v;
    v = {1'b0, q};
    return neg ? comp_t'(-v) : v;
  endfunction

endpackage

>>> src/tun_front.sv
// Edge vectors, exact cross product, magnitudes, threshold test, degenerate rounding.
// Six register stages; depends on tun_pkg.
module tun_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  tun_pkg::coord_t [8:0]       in_v,
  input  logic [tun_pkg::THR_W-1:0]   thr,
  output logic                        out_vld,
  output tun_pkg::mag_t [2:0]         out_mag,
  output tun_pkg::side_t              out_side
);
  import tun_pkg::*;

  logic [4:0] vld;
  logic signed [EDGE_W-1:0]  e1 [3];
  logic signed [EDGE_W-1:0]  e2 [3];
  logic signed [PROD_W-1:0]  prod [6];
  logic signed [CROSS_W-1:0] cp [3];
  mag_t [2:0]  mag4, mag5;
  logic [2:0]  neg4, neg5;
  logic [2:0]  big5;
  logic [THR_W-1:0] sq5 [3];
  comp_t [2:0] raw5;
  logic [SQS_W-1:0] sum;

  function automatic comp_t deg_comp(logic neg, mag_t m);
    logic [MAG_W:0] t;
    logic [MAG_W:0] one;
    quo_t q;
    one = (MAG_W+1)'(1) << NORMAL_FRAC_BITS;
    if (RD > 0) begin
      t = ({1'b0, m} + ((MAG_W+1)'(1) << RD1)) >> RD;
    end else if (LD > 0) begin
      t = ({1'b0, m} > (one >> LD)) ? one : ({1'b0, m} << LD);
    end else begin
      t = {1'b0, m};
    end
    q = (t > one) ? Q_ONE : t[Q_W-1:0];
    return pack_comp(neg, q);
  endfunction

  assign sum = SQS_W'(sq5[0]) + SQS_W'(sq5[1]) + SQS_W'(sq5[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[3:0], in_vld};
      out_vld <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EDGE_W'(in_v[3+i]) - EDGE_W'(in_v[i]);
        e2[i] <= EDGE_W'(in_v[6+i]) - EDGE_W'(in_v[i]);
      end
      prod[0] <= e1[1] * e2[2];
      prod[1] <= e1[2] * e2[1];
      prod[2] <= e1[2] * e2[0];
      prod[3] <= e1[0] * e2[2];
      prod[4] <= e1[0] * e2[1];
      prod[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
        cp[i]    <= CROSS_W'(prod[2*i]) - CROSS_W'(prod[2*i+1]);
        neg4[i]  <= cp[i][CROSS_W-1];
        mag4[i]  <= cp[i][CROSS_W-1] ? mag_t'(-cp[i]) : mag_t'(cp[i]);
        neg5[i]  <= neg4[i];
        mag5[i]  <= mag4[i];
        big5[i]  <= |mag4[i][MAG_W-1:MINL_BITS];
        sq5[i]   <= mag4[i][MINL_BITS-1:0] * mag4[i][MINL_BITS-1:0];
        raw5[i]  <= deg_comp(neg4[i], mag4[i]);
      end
      out_mag        <= mag5;
      out_side.neg   <= neg5;
      out_side.raw   <= raw5;
      out_side.degen <= !((|big5) || (sum > SQS_W'(thr)));
    end
  end

endmodule

>>> src/tun_norm.sv
// Common shift of the magnitudes to a 30-bit top and their sum of squares.
// Five register stages; depends on tun_pkg.
module tun_norm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  tun_pkg::mag_t [2:0]        in_mag,
  input  tun_pkg::side_t             in_side,
  output logic                       out_vld,
  output tun_pkg::nmag_t [2:0]       out_sm,
  output logic [tun_pkg::S2_W-1:0]   out_s2,
  output tun_pkg::side_t             out_side
);
  import tun_pkg::*;

  logic [3:0]  vld;
  mag_t        mx1;
  mag_t [2:0]  mag1, mag2;
  side_t       side1, side2, side3, side4;
  logic [BL_W-1:0] bl2;
  logic [BL_W-1:0] bl_next;
  nmag_t [2:0] sm3, sm4;
  logic [NSQ_W-1:0] sq4 [3];
  mag_t        mx_a;

  assign mx_a = (in_mag[1] > in_mag[0]) ? in_mag[1] : in_mag[0];

  always_comb begin
    bl_next = '0;
    for (int j = 0; j < MAG_W; j++) begin
      if (mx1[j]) bl_next = BL_W'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[2:0], in_vld};
      out_vld <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1   <= (in_mag[2] > mx_a) ? in_mag[2] : mx_a;
      mag1  <= in_mag;
      side1 <= in_side;
      bl2   <= bl_next;
      mag2  <= mag1;
      side2 <= side1;
      for (int i = 0; i < 3; i++) begin
        if (SH_W'(bl2) > SH_W'(NORM_TOP)) begin
          sm3[i] <= nmag_t'(mag2[i] >> (SH_W'(bl2) - SH_W'(NORM_TOP)));
        end else begin
          sm3[i] <= nmag_t'(mag2[i] << (SH_W'(NORM_TOP) - SH_W'(bl2)));
        end
        sq4[i] <= sm3[i] * sm3[i];
      end
      side3    <= side2;
      sm4      <= sm3;
      side4    <= side3;
      out_s2   <= S2_W'(sq4[0]) + S2_W'(sq4[1]) + S2_W'(sq4[2]);
      out_sm   <= sm4;
      out_side <= side4;
    end
  end

endmodule

>>> src/tun_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// ROOT_W + 1 register stages; depends on tun_pkg.
module tun_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [tun_pkg::S2_W-1:0]     in_s2,
  input  tun_pkg::nmag_t [2:0]         in_sm,
  input  tun_pkg::side_t               in_side,
  output logic                         out_vld,
  output logic [tun_pkg::ROOT_W-1:0]   out_root,
  output tun_pkg::nmag_t [2:0]         out_sm,
  output tun_pkg::side_t               out_side
);
  import tun_pkg::*;

  logic [ROOT_W:0]    vld;
  logic [S2_W-1:0]    rad  [ROOT_W+1];
  logic [REM_W-1:0]   rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  root [ROOT_W+1];
  nmag_t [2:0]        sm_p [ROOT_W+1];
  side_t              side_p [ROOT_W+1];

  assign out_vld  = vld[ROOT_W];
  assign out_root = root[ROOT_W];
  assign out_sm   = sm_p[ROOT_W];
  assign out_side = side_p[ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    if (en) begin
      rad[0]    <= in_s2;
      rem[0]    <= '0;
      root[0]   <= '0;
      sm_p[0]   <= in_sm;
      side_p[0] <= in_side;
      for (int k = 0; k < ROOT_W; k++) begin
        t     = {rem[k][REM_W-3:0], rad[k][S2_W-1 -: 2]};
        trial = REM_W'({root[k], 2'b01});
        if (t >= trial) begin
          rem[k+1]  <= t - trial;
          root[k+1] <= {root[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem[k+1]  <= t;
          root[k+1] <= {root[k][ROOT_W-2:0], 1'b0};
        end
        rad[k+1]    <= rad[k] << 2;
        sm_p[k+1]   <= sm_p[k];
        side_p[k+1] <= side_p[k];
      end
    end
  end

endmodule

>>> src/tun_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, rounded quotient.
// Q_W + 1 register stages; depends on tun_pkg.
module tun_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [tun_pkg::ROOT_W-1:0]   in_root,
  input  tun_pkg::nmag_t [2:0]         in_sm,
  input  tun_pkg::side_t               in_side,
  output logic                         out_vld,
  output tun_pkg::quo_t [2:0]          out_q,
  output tun_pkg::side_t               out_side
);
  import tun_pkg::*;

  logic [Q_W:0]         vld;
  logic [NUM_W-1:0]     num [Q_W+1][3];
  logic [ROOT_W-1:0]    den [Q_W+1];
  quo_t [2:0]           q_p [Q_W+1];
  side_t                side_p [Q_W+1];

  assign out_vld  = vld[Q_W];
  assign out_q    = q_p[Q_W];
  assign out_side = side_p[Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W:0] d;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num[0][i] <= (NUM_W'(in_sm[i]) << NORMAL_FRAC_BITS) + NUM_W'(in_root >> 1);
      end
      den[0]    <= in_root;
      q_p[0]    <= '0;
      side_p[0] <= in_side;
      for (int j = 0; j < Q_W; j++) begin
        d = (NUM_W+1)'(den[j]) << (Q_W - 1 - j);
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, num[j][i]} >= d) begin
            num[j+1][i] <= NUM_W'({1'b0, num[j][i]} - d);
            q_p[j+1][i] <= {q_p[j][i][Q_W-2:0], 1'b1};
          end else begin
            num[j+1][i] <= num[j][i];
            q_p[j+1][i] <= {q_p[j][i][Q_W-2:0], 1'b0};
          end
        end
        den[j+1]    <= den[j];
        side_p[j+1] <= side_p[j];
      end
    end
  end

endmodule

>>> src/triangle_unit_normal.sv
// Triangle unit normal: one triangle per clock, fully pipelined, results in input order.
// Latency from request to result is set mostly by the 32-stage square root
// and the 16-stage divider; a stall on the result side freezes the whole pipeline.
// Depends on tun_pkg, tun_front, tun_norm, tun_sqrt and tun_div.
module triangle_unit_normal (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [tun_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [tun_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // degenerate
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tun_pkg::MINL_BITS-1:0]       cfg_data
);
  import tun_pkg::*;

  logic en;
  logic [MINL_BITS-1:0] min_length;
  logic [THR_W-1:0]     thr;
  coord_t [8:0]         in_v;

  logic        f_vld, n_vld, s_vld, d_vld;
  mag_t [2:0]  f_mag;
  side_t       f_side, n_side, s_side, d_side;
  nmag_t [2:0] n_sm, s_sm;
  logic [S2_W-1:0]   n_s2;
  logic [ROOT_W-1:0] s_root;
  quo_t [2:0]  d_q;
  comp_t [2:0] normal;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      in_v[i] = coord_t'(s_axis_tdata[i*COORD_BITS +: COORD_BITS]);
    end
    for (int i = 0; i < 3; i++) begin
      normal[i] = d_side.degen ? d_side.raw[i]
                : pack_comp(d_side.neg[i], (d_q[i] > Q_ONE) ? Q_ONE : d_q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MINL_RESET;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    thr <= min_length * min_length;
  end

  tun_front u_front (
    .clk, .rst, .en,
    .in_vld   (s_axis_tvalid),
    .in_v     (in_v),
    .thr      (thr),
    .out_vld  (f_vld),
    .out_mag  (f_mag),
    .out_side (f_side)
  );

  tun_norm u_norm (
    .clk, .rst, .en,
    .in_vld   (f_vld),
    .in_mag   (f_mag),
    .in_side  (f_side),
    .out_vld  (n_vld),
    .out_sm   (n_sm),
    .out_s2   (n_s2),
    .out_side (n_side)
  );

  tun_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_vld   (n_vld),
    .in_s2    (n_s2),
    .in_sm    (n_sm),
    .in_side  (n_side),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_sm   (s_sm),
    .out_side (s_side)
  );

  tun_div u_div (
    .clk, .rst, .en,
    .in_vld   (s_vld),
    .in_root  (s_root),
    .in_sm    (s_sm),
    .in_side  (s_side),
    .out_vld  (d_vld),
    .out_q    (d_q),
    .out_side (d_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OUT_DATA_W'(normal);
      m_axis_tuser <= d_side.degen;
    end
  end

endmodule

>>> src/tun_check.sv
// Port checker for triangle_unit_normal, bound to the top level.
// Depends on tun_pkg and triangle_unit_normal_assert.svh.
`include "triangle_unit_normal_assert.svh"

module tun_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tun_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import tun_pkg::*;

  logic signed [OUT_W-1:0] nx, ny, nz;

  assign nx = m_axis_tdata[OUT_W-1:0];
  assign ny = m_axis_tdata[2*OUT_W-1:OUT_W];
  assign nz = m_axis_tdata[3*OUT_W-1:2*OUT_W];

  `TUN_CHECK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `TUN_CHECK(a_x_range, m_axis_tvalid |-> (nx <= 16384) && (nx >= -16384))
  `TUN_CHECK(a_y_range, m_axis_tvalid |-> (ny <= 16384) && (ny >= -16384))
  `TUN_CHECK(a_z_range, m_axis_tvalid |-> (nz <= 16384) && (nz >= -16384))
  `TUN_CHECK_ALWAYS(a_reset_empty, $past(rst) |-> !m_axis_tvalid)

endmodule

bind triangle_unit_normal tun_check u_check (.*);

>>> dv/triangle_unit_normal_tb.sv
// Testbench for triangle_unit_normal: drives triangles over the stream input, predicts
// the unit normal or degenerate raw cross product, and checks results in order.
// Depends on tun_pkg and the triangle_unit_normal RTL.
module triangle_unit_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tun_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] nz;
    logic [OUT_W-1:0] ny;
    logic [OUT_W-1:0] nx;
    logic             degen;
  } normal_t;

  class normal_board;
    logic [MINL_BITS-1:0] min_len;
    normal_t pending[$];
    int errors;

    function new();
      min_len = MINL_RESET;
      errors = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'h1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function normal_t face_normal(logic [IN_W-1:0] tri_bits);
      longint v[9];
      longint e1[3], e2[3], n[3];
      logic [63:0] mag[3];
      logic [127:0] sum, thr;
      logic [63:0] mx, s2, len, q, one;
      logic [OUT_W-1:0] o[3];
      int b, d;
      normal_t r;
      one = 64'h1 << NORMAL_FRAC_BITS;
      for (int i = 0; i < 9; i++)
        v[i] = longint'(coord_t'(tri_bits[i*COORD_BITS +: COORD_BITS]));
      for (int i = 0; i < 3; i++) begin
        e1[i] = v[3+i] - v[i];
        e2[i] = v[6+i] - v[i];
      end
      n[0] = e1[1]*e2[2] - e1[2]*e2[1];
      n[1] = e1[2]*e2[0] - e1[0]*e2[2];
      n[2] = e1[0]*e2[1] - e1[1]*e2[0];
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = n[i] < 0 ? -n[i] : n[i];
        sum += 128'(mag[i]) * 128'(mag[i]);
      end
      thr = 128'(min_len) * 128'(min_len);
      if (sum > thr) begin
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        b = 0;
        while ((mx >> b) != 0) b++;
        s2 = 0;
        for (int i = 0; i < 3; i++) begin
          if (b > NORM_TOP) mag[i] >>= (b - NORM_TOP);
          else mag[i] <<= (NORM_TOP - b);
          s2 += mag[i] * mag[i];
        end
        len = root64(s2);
        for (int i = 0; i < 3; i++) begin
          q = ((mag[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
          if (q > one) q = one;
          o[i] = n[i] < 0 ? OUT_W'(-q) : OUT_W'(q);
        end
        r.degen = 1'b0;
      end else begin
        d = 2*COORD_FRAC_BITS - NORMAL_FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
          q = (mag[i] + (64'h1 << (d-1))) >> d;
          if (q > one) q = one;
          o[i] = n[i] < 0 ? OUT_W'(-q) : OUT_W'(q);
        end
        r.degen = 1'b1;
      end
      r.nx = o[0]; r.ny = o[1]; r.nz = o[2];
      return r;
    endfunction

    function void note_triangle(logic [IN_W-1:0] tri_bits);
      pending = {pending, face_normal(tri_bits)};
    endfunction

    function void check_normal(normal_t got);
      normal_t exp_n;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_n = pending.pop_front();
      if (got !== exp_n) begin
        $display("%0t: mismatch expected x=%h y=%h z=%h deg=%b actual x=%h y=%h z=%h deg=%b",
                 $realtime, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen,
                 got.nx, got.ny, got.nz, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 0, cfg_ready;
  logic [MINL_BITS-1:0] cfg_data = '0;

  int send_idle = 0, recv_stall = 0;
  normal_board board = new();

  triangle_unit_normal dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_normal({m_axis_tdata[3*OUT_W-1:2*OUT_W], m_axis_tdata[2*OUT_W-1:OUT_W],
                            m_axis_tdata[OUT_W-1:0], m_axis_tuser});
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(8191) - 4096);
      default: return coord_t'($urandom_range(3));
    endcase
  endfunction

  task automatic send_triangle(logic [IN_W-1:0] tri_bits);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= IN_DATA_W'(tri_bits);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_triangle(tri_bits);
  endtask

  task automatic send_vertices(coord_t c[9]);
    logic [IN_W-1:0] t;
    for (int i = 0; i < 9; i++) t[i*COORD_BITS +: COORD_BITS] = c[i];
    send_triangle(t);
  endtask

  task automatic write_min_len(logic [MINL_BITS-1:0] val);
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.min_len = val;
    cfg_valid <= 0;
  endtask

  task automatic random_run(int count, int idle, int stall);
    coord_t c[9];
    int mode;
    send_idle = idle;
    recv_stall = stall;
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(5);
      for (int i = 0; i < 9; i++) c[i] = rand_coord(mode < 3 ? 0 : mode - 3);
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
      end
      send_vertices(c);
    end
  endtask

  initial begin
    coord_t c[9];
    logic [MINL_BITS-1:0] settings[4];
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_vertices(c);
    c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
    send_vertices(c);
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_vertices(c);
    c = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
    send_vertices(c);
    c = '{-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
          -8388608, 8388607, 8388607};
    send_vertices(c);
    c = '{8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
          8388607, -8388608, -8388608};
    send_vertices(c);
    c = '{0, 0, 0, 40, 0, 0, 0, 42, 0};
    send_vertices(c);
    c = '{0, 0, 0, 41, 0, 0, 0, 41, 0};
    send_vertices(c);
    c = '{0, 0, 0, 8388607, 0, 0, 0, 0, 8388607};
    send_vertices(c);
    c = '{5, 5, 5, 10, 10, 10, 20, 20, 20};
    send_vertices(c);
    random_run(375, 0, 0);
    settings = '{25'd0, 25'd16777216, 25'd1 << 20, MINL_RESET};
    for (int p = 0; p < 4; p++) begin
      write_min_len(settings[p]);
      case (p)
        0: random_run(375, 51, 0);
        1: random_run(375, 0, 51);
        2: random_run(375, 17, 17);
        default: random_run(40, 0, 0);
      endcase
    end
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end
endmodule
